FILE: rtl/audio_stream_ring_refill_tracker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the playback ring refill tracker
// Concurrent property wrappers shared by the RTL of the block.
// ----------------------------------------------------------------------------
`ifndef AUDIO_STREAM_RING_REFILL_TRACKER_ASSERT_SVH
`define AUDIO_STREAM_RING_REFILL_TRACKER_ASSERT_SVH

// Same-cycle implication, quiet while reset is held.
`define ASRRT_ASSERT_HOLDS(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("asrrt: invariant violated");

// Next-cycle implication, quiet while reset is held.
`define ASRRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("asrrt: sequence violated");

`endif

FILE: rtl/asrrt_pkg.sv
// ----------------------------------------------------------------------------
// asrrt_pkg
// Beat types, operation and result codes, and the microcode ROM of the
// playback ring refill tracker.
// ----------------------------------------------------------------------------
package asrrt_pkg;

    // Input and output beats
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] elapsed_ticks;
        logic [16:0] returned_count;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] fill_start;
        logic [16:0] fill_length;
        logic [31:0] play_position;
    } t_out_beat;

    // Operations
    localparam logic [1:0] OP_PAGE_TICK = 2'd0;
    localparam logic [1:0] OP_UPDATE    = 2'd1;
    localparam logic [1:0] OP_FILL_DONE = 2'd2;
    localparam logic [1:0] OP_QUERY     = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_ACK      = 2'd0;
    localparam logic [1:0] KIND_FILL_REQ = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;
    localparam logic [1:0] KIND_POSITION = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_STREAM_ON    = 2'd0;
    localparam logic [1:0] CFG_PAGE_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_PAGE_TICKS   = 2'd2;
    localparam logic [1:0] CFG_SAMPLE_TIMER = 2'd3;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_PAGE_LENGTH  = 16'd1024;
    localparam logic [25:0] RST_PAGE_TICKS   = 26'd32768;
    localparam logic [15:0] RST_SAMPLE_TIMER = 16'd32;

    // Fine offset scale is 32 ticks-per-timer units: a 5-bit shift
    localparam int FINE_SHIFT = 5;

    // Micro-operations
    typedef logic [4:0] t_uop;
    localparam t_uop UOP_NOP       = 5'd0;
    localparam t_uop UOP_ACK       = 5'd1;
    localparam t_uop UOP_ZPOS      = 5'd2;
    localparam t_uop UOP_TICK      = 5'd3;
    localparam t_uop UOP_DIV_TICKS = 5'd4;
    localparam t_uop UOP_DIV_STEP  = 5'd5;
    localparam t_uop UOP_DIV_FINE  = 5'd6;
    localparam t_uop UOP_DIV_POS   = 5'd7;
    localparam t_uop UOP_SET_RD    = 5'd8;
    localparam t_uop UOP_SET_WR    = 5'd9;
    localparam t_uop UOP_REQUEST   = 5'd10;
    localparam t_uop UOP_MUL       = 5'd11;
    localparam t_uop UOP_QUERY_OUT = 5'd12;
    localparam t_uop UOP_DIV_RDP   = 5'd13;
    localparam t_uop UOP_RD_MOD    = 5'd14;
    localparam t_uop UOP_WR_MOD    = 5'd15;
    localparam t_uop UOP_ADVANCE   = 5'd16;
    localparam t_uop UOP_COMPLETE  = 5'd17;

    // Jump conditions
    typedef logic [2:0] t_cond;
    localparam t_cond COND_NONE      = 3'd0;
    localparam t_cond COND_LOOP      = 3'd1;
    localparam t_cond COND_NO_REFILL = 3'd2;
    localparam t_cond COND_BAD_COUNT = 3'd3;
    localparam t_cond COND_WR_NE_RD  = 3'd4;

    typedef logic [4:0] t_upc;

    typedef struct packed {
        t_uop  uop;
        t_cond cond;
        t_upc  target;
        logic  fin;
    } t_cw;

    // Program entry points
    localparam t_upc A_ACK    = 5'd0;
    localparam t_upc A_ZPOS   = 5'd1;
    localparam t_upc A_TICK   = 5'd2;
    localparam t_upc A_UPDATE = 5'd3;
    localparam t_upc A_REQ    = 5'd12;
    localparam t_upc A_QUERY  = 5'd13;
    localparam t_upc A_FILL   = 5'd19;
    localparam t_upc A_DONE   = 5'd27;

    function automatic t_cw mk_cw(input t_uop u, input t_cond c, input t_upc t,
                                  input logic f);
        t_cw w;
        w.uop    = u;
        w.cond   = c;
        w.target = t;
        w.fin    = f;
        return w;
    endfunction

    // Microcode ROM
    function automatic t_cw ucode(input t_upc a);
        t_cw w;
        case (a)
            // stopped / trivial programs
            5'd0:  w = mk_cw(UOP_ACK,       COND_NONE,      5'd0,  1'b1);
            5'd1:  w = mk_cw(UOP_ZPOS,      COND_NONE,      5'd0,  1'b1);
            5'd2:  w = mk_cw(UOP_TICK,      COND_NONE,      5'd0,  1'b1);
            // update
            5'd3:  w = mk_cw(UOP_DIV_TICKS, COND_NONE,      5'd0,  1'b0);
            5'd4:  w = mk_cw(UOP_DIV_STEP,  COND_LOOP,      5'd4,  1'b0);
            5'd5:  w = mk_cw(UOP_DIV_FINE,  COND_NONE,      5'd0,  1'b0);
            5'd6:  w = mk_cw(UOP_DIV_STEP,  COND_LOOP,      5'd6,  1'b0);
            5'd7:  w = mk_cw(UOP_DIV_POS,   COND_NONE,      5'd0,  1'b0);
            5'd8:  w = mk_cw(UOP_DIV_STEP,  COND_LOOP,      5'd8,  1'b0);
            5'd9:  w = mk_cw(UOP_SET_RD,    COND_NONE,      5'd0,  1'b0);
            5'd10: w = mk_cw(UOP_DIV_STEP,  COND_LOOP,      5'd10, 1'b0);
            5'd11: w = mk_cw(UOP_SET_WR,    COND_NONE,      5'd0,  1'b0);
            5'd12: w = mk_cw(UOP_REQUEST,   COND_NONE,      5'd0,  1'b1);
            // query
            5'd13: w = mk_cw(UOP_DIV_TICKS, COND_NONE,      5'd0,  1'b0);
            5'd14: w = mk_cw(UOP_DIV_STEP,  COND_LOOP,      5'd14, 1'b0);
            5'd15: w = mk_cw(UOP_DIV_FINE,  COND_NONE,      5'd0,  1'b0);
            5'd16: w = mk_cw(UOP_DIV_STEP,  COND_LOOP,      5'd16, 1'b0);
            5'd17: w = mk_cw(UOP_MUL,       COND_NONE,      5'd0,  1'b0);
            5'd18: w = mk_cw(UOP_QUERY_OUT, COND_NONE,      5'd0,  1'b1);
            // fill done
            5'd19: w = mk_cw(UOP_NOP,       COND_NO_REFILL, A_ACK, 1'b0);
            5'd20: w = mk_cw(UOP_DIV_RDP,   COND_NONE,      5'd0,  1'b0);
            5'd21: w = mk_cw(UOP_DIV_STEP,  COND_LOOP,      5'd21, 1'b0);
            5'd22: w = mk_cw(UOP_RD_MOD,    COND_NONE,      5'd0,  1'b0);
            5'd23: w = mk_cw(UOP_DIV_STEP,  COND_LOOP,      5'd23, 1'b0);
            5'd24: w = mk_cw(UOP_WR_MOD,    COND_BAD_COUNT, A_DONE, 1'b0);
            5'd25: w = mk_cw(UOP_ADVANCE,   COND_NONE,      5'd0,  1'b0);
            5'd26: w = mk_cw(UOP_NOP,       COND_WR_NE_RD,  A_REQ, 1'b0);
            5'd27: w = mk_cw(UOP_COMPLETE,  COND_NONE,      5'd0,  1'b1);
            default: w = mk_cw(UOP_ACK,     COND_NONE,      5'd0,  1'b1);
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/audio_stream_ring_refill_tracker.sv
// ----------------------------------------------------------------------------
// audio_stream_ring_refill_tracker
// Read/write pointer tracker for a two-page playback ring, run by a small
// microcoded sequencer around one shared restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (i_in_valid / o_in_ready) carry one operation: page tick,
//   update, fill done or position query. Every input beat produces exactly
//   one output beat (o_out_valid / i_out_ready): acknowledge, fill request,
//   refill complete or position.
//   One beat is worked at a time. A step counter walks a control ROM; each
//   division (ticks by page period, remainder by sample timer, position and
//   pointers by ring length) is 32 passes of the shared divider. The next
//   beat is taken in the cycle after the result is loaded, even while that
//   result still waits; no new beat is taken while a program runs.
//   When the receiver stalls, the result holds in the output register and
//   the sequencer holds at its final step until space frees. Reset clears
//   the pointers, page count and refill state, loads default configuration
//   and leaves both channels empty. Configuration writes land at once; write
//   only while idle. A write to stream_on also clears the pointers.
// ----------------------------------------------------------------------------
`include "audio_stream_ring_refill_tracker_assert.svh"

module audio_stream_ring_refill_tracker #(
    parameter int MAX_PAGE_LEN = 32768
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  asrrt_pkg::t_in_beat  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output asrrt_pkg::t_out_beat o_out,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [25:0]          i_cfg_data
);
    import asrrt_pkg::*;

    // Configuration
    logic        r_stream_on,    n_stream_on;
    logic [15:0] r_page_length,  n_page_length;
    logic [25:0] r_page_ticks,   n_page_ticks;
    logic [15:0] r_sample_timer, n_sample_timer;

    // Architectural state
    logic [31:0] r_page_count,    n_page_count;
    logic [15:0] r_read_pointer,  n_read_pointer;
    logic [15:0] r_write_pointer, n_write_pointer;
    logic [16:0] r_pending,       n_pending;
    logic        r_refilling,     n_refilling;

    // Sequencer
    logic        r_busy, n_busy;
    t_upc        r_upc,  n_upc;
    logic [4:0]  r_bit_cnt, n_bit_cnt;
    t_in_beat    r_item, n_item;

    // Datapath
    logic [31:0] r_dvd, n_dvd;   // dividend in, quotient out
    logic [25:0] r_rem, n_rem;
    logic [25:0] r_dsr, n_dsr;
    logic [31:0] r_a,   n_a;     // page number
    logic [31:0] r_b,   n_b;     // page number times page length
    logic [16:0] r_rd,  n_rd;
    logic [16:0] r_wr,  n_wr;

    // Output register
    logic        r_out_valid, n_out_valid;
    t_out_beat   r_out,       n_out;

    t_cw         cw;
    logic        step_en;
    logic        accept;
    t_upc        entry;
    logic [15:0] pl_floor;
    logic [15:0] eff_page;
    logic [16:0] ring;
    logic [25:0] per;
    logic [25:0] tim;
    logic [26:0] div_try;
    logic [26:0] dsr_ext;
    logic [26:0] div_diff;
    logic        div_ge;
    logic [31:0] mul_full;
    logic [16:0] req_len;
    logic [17:0] adv_sum;
    logic        bad_count;
    logic        jump;

    assign o_in_ready  = !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign accept      = i_in_valid && !r_busy;

    // Effective page length: floor to 32, never zero, clamp to the maximum
    always_comb begin
        pl_floor = r_page_length & ~16'd31;
        eff_page = pl_floor;
        if (pl_floor == 16'd0) begin
            eff_page = 16'd32;
        end
        if (32'(pl_floor) > 32'(MAX_PAGE_LEN)) begin
            eff_page = MAX_PAGE_LEN[15:0];
        end
    end

    assign ring = {eff_page, 1'b0};
    assign per  = (r_page_ticks == 26'd0) ? 26'd1 : r_page_ticks;
    assign tim  = (r_sample_timer == 16'd0) ? 26'd1 : 26'(r_sample_timer);

    // One restoring divider pass: shift in the next dividend bit, try subtract
    assign dsr_ext  = {1'b0, r_dsr};
    assign div_try  = {r_rem, r_dvd[31]};
    assign div_ge   = div_try >= dsr_ext;
    assign div_diff = div_try - dsr_ext;

    // Position wraps modulo 2^32: keep the low product bits only
    assign mul_full = r_a * 32'(eff_page);

    // Next request runs to the read pointer, or to the ring end
    assign req_len   = (r_rd > r_wr) ? (r_rd - r_wr) : (ring - r_wr);
    assign adv_sum   = {1'b0, r_wr} + {1'b0, r_item.returned_count};
    assign bad_count = (r_item.returned_count == 17'd0) ||
                       (r_item.returned_count > r_pending);

    assign cw      = ucode(r_upc);
    assign step_en = r_busy && !(cw.fin && r_out_valid && !i_out_ready);

    // Program entry by operation; a stopped stream acknowledges, or answers a query with position zero
    always_comb begin
        if (!r_stream_on) begin
            entry = (i_in.operation == OP_QUERY) ? A_ZPOS : A_ACK;
        end else begin
            case (i_in.operation)
                OP_PAGE_TICK: entry = A_TICK;
                OP_UPDATE:    entry = A_UPDATE;
                OP_FILL_DONE: entry = A_FILL;
                OP_QUERY:     entry = A_QUERY;
                default:      entry = A_ACK;
            endcase
        end
    end

    always_comb begin
        case (cw.cond)
            COND_LOOP:      jump = (r_bit_cnt != 5'd0);
            COND_NO_REFILL: jump = !r_refilling;
            COND_BAD_COUNT: jump = bad_count;
            COND_WR_NE_RD:  jump = (r_wr != r_rd);
            default:        jump = 1'b0;
        endcase
    end

    always_comb begin
        n_stream_on     = r_stream_on;
        n_page_length   = r_page_length;
        n_page_ticks    = r_page_ticks;
        n_sample_timer  = r_sample_timer;
        n_page_count    = r_page_count;
        n_read_pointer  = r_read_pointer;
        n_write_pointer = r_write_pointer;
        n_pending       = r_pending;
        n_refilling     = r_refilling;
        n_busy          = r_busy;
        n_upc           = r_upc;
        n_bit_cnt       = r_bit_cnt;
        n_item          = r_item;
        n_dvd           = r_dvd;
        n_rem           = r_rem;
        n_dsr           = r_dsr;
        n_a             = r_a;
        n_b             = r_b;
        n_rd            = r_rd;
        n_wr            = r_wr;
        n_out_valid     = r_out_valid;
        n_out           = r_out;

        // Configuration writes; opening or closing the stream clears state
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STREAM_ON: begin
                    n_stream_on     = i_cfg_data[0];
                    n_page_count    = 32'd0;
                    n_read_pointer  = 16'd0;
                    n_write_pointer = 16'd0;
                    n_pending       = 17'd0;
                    n_refilling     = 1'b0;
                end
                CFG_PAGE_LENGTH:  n_page_length  = i_cfg_data[15:0];
                CFG_PAGE_TICKS:   n_page_ticks   = i_cfg_data;
                CFG_SAMPLE_TIMER: n_sample_timer = i_cfg_data[15:0];
                default: ;
            endcase
        end

        if (accept) begin
            n_item = i_in;
            n_busy = 1'b1;
            n_upc  = entry;
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (step_en) begin
            case (cw.uop)
                UOP_ACK: begin
                    n_out = '{KIND_ACK, 16'd0, 17'd0, 32'd0};
                end
                UOP_ZPOS: begin
                    n_out = '{KIND_POSITION, 16'd0, 17'd0, 32'd0};
                end
                UOP_TICK: begin
                    n_page_count = r_page_count + 32'd1;
                    n_out        = '{KIND_ACK, 16'd0, 17'd0, 32'd0};
                end
                UOP_DIV_TICKS: begin
                    n_dvd     = r_item.elapsed_ticks;
                    n_dsr     = per;
                    n_rem     = 26'd0;
                    n_bit_cnt = 5'd31;
                end
                UOP_DIV_STEP: begin
                    n_rem     = div_ge ? div_diff[25:0] : div_try[25:0];
                    n_dvd     = {r_dvd[30:0], div_ge};
                    n_bit_cnt = r_bit_cnt - 5'd1;
                end
                UOP_DIV_FINE: begin
                    // page number on a copy; remainder scaled for the fine offset
                    n_a       = r_page_count + r_dvd;
                    n_dvd     = 32'({r_rem, FINE_SHIFT'(0)});
                    n_dsr     = tim;
                    n_rem     = 26'd0;
                    n_bit_cnt = 5'd31;
                end
                UOP_DIV_POS: begin
                    n_dvd     = (r_a[0] ? 32'(eff_page) : 32'd0) + r_dvd;
                    n_dsr     = 26'(ring);
                    n_rem     = 26'd0;
                    n_bit_cnt = 5'd31;
                end
                UOP_SET_RD: begin
                    n_rd           = r_rem[16:0] & ~17'd3;
                    n_read_pointer = r_rem[15:0] & ~16'd3;
                    n_dvd          = 32'(r_write_pointer);
                    n_dsr          = 26'(ring);
                    n_rem          = 26'd0;
                    n_bit_cnt      = 5'd31;
                end
                UOP_SET_WR: begin
                    n_wr            = r_rem[16:0];
                    n_write_pointer = r_rem[15:0];
                end
                UOP_REQUEST: begin
                    n_pending   = req_len;
                    n_refilling = 1'b1;
                    n_out       = '{KIND_FILL_REQ, r_wr[15:0], req_len, 32'd0};
                end
                UOP_MUL: begin
                    n_b = mul_full;
                end
                UOP_QUERY_OUT: begin
                    n_out = '{KIND_POSITION, 16'd0, 17'd0, r_b + r_dvd};
                end
                UOP_DIV_RDP: begin
                    n_dvd     = 32'(r_read_pointer);
                    n_dsr     = 26'(ring);
                    n_rem     = 26'd0;
                    n_bit_cnt = 5'd31;
                end
                UOP_RD_MOD: begin
                    n_rd      = r_rem[16:0];
                    n_dvd     = 32'(r_write_pointer);
                    n_dsr     = 26'(ring);
                    n_rem     = 26'd0;
                    n_bit_cnt = 5'd31;
                end
                UOP_WR_MOD: begin
                    n_wr = r_rem[16:0];
                end
                UOP_ADVANCE: begin
                    // wrap to zero at the ring end
                    if (adv_sum >= {1'b0, ring}) begin
                        n_wr = 17'd0;
                    end else begin
                        n_wr = adv_sum[16:0];
                    end
                    n_write_pointer = n_wr[15:0];
                end
                UOP_COMPLETE: begin
                    n_refilling = 1'b0;
                    n_pending   = 17'd0;
                    n_out       = '{KIND_COMPLETE, r_wr[15:0], 17'd0, 32'd0};
                end
                default: ;
            endcase

            if (cw.fin) begin
                n_out_valid = 1'b1;
                n_busy      = 1'b0;
            end else if (jump) begin
                n_upc = cw.target;
            end else begin
                n_upc = r_upc + t_upc'(1);
            end
        end
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_on     <= 1'b0;
            r_page_length   <= RST_PAGE_LENGTH;
            r_page_ticks    <= RST_PAGE_TICKS;
            r_sample_timer  <= RST_SAMPLE_TIMER;
            r_page_count    <= 32'd0;
            r_read_pointer  <= 16'd0;
            r_write_pointer <= 16'd0;
            r_pending       <= 17'd0;
            r_refilling     <= 1'b0;
            r_busy          <= 1'b0;
            r_upc           <= A_ACK;
            r_bit_cnt       <= 5'd0;
            r_out_valid     <= 1'b0;
        end else begin
            r_stream_on     <= n_stream_on;
            r_page_length   <= n_page_length;
            r_page_ticks    <= n_page_ticks;
            r_sample_timer  <= n_sample_timer;
            r_page_count    <= n_page_count;
            r_read_pointer  <= n_read_pointer;
            r_write_pointer <= n_write_pointer;
            r_pending       <= n_pending;
            r_refilling     <= n_refilling;
            r_busy          <= n_busy;
            r_upc           <= n_upc;
            r_bit_cnt       <= n_bit_cnt;
            r_out_valid     <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_dsr  <= n_dsr;
        r_a    <= n_a;
        r_b    <= n_b;
        r_rd   <= n_rd;
        r_wr   <= n_wr;
        r_out  <= n_out;
    end

    // An accepted beat starts a program
    `ASRRT_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, accept, r_busy)
    // A refill in flight always has a nonzero request outstanding
    `ASRRT_ASSERT_HOLDS(a_refill_pending, i_clk, i_rst_n, r_refilling, r_pending != 17'd0)
    // No request outstanding once the refill has ended
    `ASRRT_ASSERT_HOLDS(a_idle_no_pending, i_clk, i_rst_n, !r_refilling, r_pending == 17'd0)
    // Divider remainder stays below the divisor on every pass
    `ASRRT_ASSERT_HOLDS(a_div_rem_bound, i_clk, i_rst_n,
        step_en && (cw.uop == UOP_DIV_STEP), r_rem < r_dsr)

endmodule
